[sv/bgre_pkg.sv]
package bgre_pkg;

    // grid geometry
    localparam int MAX_DIM    = 64;
    localparam int CELL_COUNT = MAX_DIM * MAX_DIM;
    localparam int IDX_W      = $clog2(MAX_DIM);
    localparam int DIM_W      = $clog2(MAX_DIM + 1);
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int CNT_W      = $clog2(CELL_COUNT + 1);
    localparam int AREA_W     = 13;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic [IDX_W-1:0]  tall_row;
        logic [IDX_W-1:0]  tall_col;
        logic [DIM_W-1:0]  tall_height;
        logic [IDX_W-1:0]  wide_row;
        logic [IDX_W-1:0]  wide_col;
        logic [DIM_W-1:0]  wide_width;
        logic [IDX_W-1:0]  big_row;
        logic [IDX_W-1:0]  big_col;
        logic [AREA_W-1:0] big_area;
    } t_result;

    // zero counts as one, anything above the maximum as the maximum
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            res = DIM_W'(MAX_DIM);
        end
        return res;
    endfunction

endpackage

[sv/bgre_pix_if.sv]
interface bgre_pix_if;
    logic valid;
    logic ready;
    logic pixel;

    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface

[sv/bgre_res_if.sv]
interface bgre_res_if;
    logic                          valid;
    logic                          ready;
    logic [bgre_pkg::IDX_W-1:0]    tall_row;
    logic [bgre_pkg::IDX_W-1:0]    tall_col;
    logic [bgre_pkg::DIM_W-1:0]    tall_height;
    logic [bgre_pkg::IDX_W-1:0]    wide_row;
    logic [bgre_pkg::IDX_W-1:0]    wide_col;
    logic [bgre_pkg::DIM_W-1:0]    wide_width;
    logic [bgre_pkg::IDX_W-1:0]    big_row;
    logic [bgre_pkg::IDX_W-1:0]    big_col;
    logic [bgre_pkg::AREA_W-1:0]   big_area;

    modport source (
        output valid, tall_row, tall_col, tall_height, wide_row, wide_col, wide_width,
               big_row, big_col, big_area,
        input  ready
    );
    modport sink (
        input  valid, tall_row, tall_col, tall_height, wide_row, wide_col, wide_width,
               big_row, big_col, big_area,
        output ready
    );
endinterface

[sv/binary_grid_rectangle_extents.sv]
// Binary grid rectangle extents.
// Pixels arrive on i_pix in raster order, one per transaction, and are kept
// in a 4096 x 1 grid memory. Configuration writes (i_cfg_we, i_cfg_idx,
// i_cfg_data) set the row count (index 0) and column count (index 1); both
// reset to 64, zero is taken as 1 and anything above 64 as 64.
// While loading, one pixel is taken every cycle. The transaction that
// carries the last pixel of the grid starts a scan: the grid memory is read
// once, one cell per cycle in reverse raster order, with the down run of the
// row below held in a 64-entry column memory. Each cell then passes through
// the scan pipeline, and once the last cell has left it and the done flag
// is set, one result transaction on o_res reports the tallest, widest and
// largest-area runs when the output register is free.
// No pixel is taken during the scan. After the scan the result sits in the
// output register until the receiver takes it; loading of the next grid
// goes on meanwhile, but the next scan result waits for the register.
// Reset is synchronous: the load count returns to zero, the registers to
// 64 and the output goes empty. The grid memory itself is not cleared.
module binary_grid_rectangle_extents (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    bgre_pix_if.sink                          i_pix,
    bgre_res_if.source                        o_res,
    input  logic                              i_cfg_we,
    input  logic [bgre_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bgre_pkg::DIM_W-1:0]        i_cfg_data
);

    logic [bgre_pkg::DIM_W-1:0]    r_rows;
    logic [bgre_pkg::DIM_W-1:0]    r_cols;
    logic [bgre_pkg::CNT_W-1:0]    r_count;
    logic [bgre_pkg::CNT_W-1:0]    n_count;
    bgre_pkg::t_state              r_state;
    bgre_pkg::t_state              n_state;
    logic                          r_out_vld;
    bgre_pkg::t_result             r_out;

    logic [bgre_pkg::DIM_W-1:0]    rows_c;
    logic [bgre_pkg::DIM_W-1:0]    cols_c;
    logic [2*bgre_pkg::DIM_W-1:0]  total_prod;
    logic [bgre_pkg::CNT_W-1:0]    total;
    logic                          accept;
    logic                          last_pix;
    logic                          pix_ready;
    logic                          out_load;
    logic                          scan_done;
    logic [bgre_pkg::ADDR_W-1:0]   scan_addr;
    logic                          scan_pix;
    bgre_pkg::t_result             scan_res;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= bgre_pkg::DIM_W'(bgre_pkg::MAX_DIM);
            r_cols <= bgre_pkg::DIM_W'(bgre_pkg::MAX_DIM);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bgre_pkg::CFG_ROWS: r_rows <= i_cfg_data;
                bgre_pkg::CFG_COLS: r_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign rows_c     = bgre_pkg::clamp_dim(r_rows);
    assign cols_c     = bgre_pkg::clamp_dim(r_cols);
    assign total_prod = rows_c * cols_c;
    assign total      = total_prod[bgre_pkg::CNT_W-1:0];

    // load counting
    assign accept   = i_pix.valid && pix_ready;
    assign n_count  = r_count + bgre_pkg::CNT_W'(1);
    assign last_pix = accept && (n_count >= total);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (accept) begin
            r_count <= last_pix ? '0 : n_count;
        end
    end

    // pixel store
    bgre_ram #(
        .DEPTH (bgre_pkg::CELL_COUNT),
        .WIDTH (1)
    ) u_grid_mem (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_count[bgre_pkg::ADDR_W-1:0]),
        .i_wdata (i_pix.pixel),
        .i_raddr (scan_addr),
        .o_rdata (scan_pix)
    );

    bgre_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (last_pix),
        .i_rows    (rows_c),
        .i_cols    (cols_c),
        .i_total   (total),
        .o_rd_addr (scan_addr),
        .i_rd_data (scan_pix),
        .o_done    (scan_done),
        .o_result  (scan_res)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bgre_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bgre_pkg::ST_LOAD: begin
                if (last_pix) n_state = bgre_pkg::ST_SCAN;
            end
            bgre_pkg::ST_SCAN: begin
                if (scan_done) n_state = bgre_pkg::ST_HOLD;
            end
            bgre_pkg::ST_HOLD: begin
                if (out_load) n_state = bgre_pkg::ST_LOAD;
            end
            default: n_state = bgre_pkg::ST_LOAD;
        endcase
    end

    // state outputs
    always_comb begin
        pix_ready = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            bgre_pkg::ST_LOAD: pix_ready = 1'b1;
            bgre_pkg::ST_SCAN: ;
            bgre_pkg::ST_HOLD: out_load = !r_out_vld || o_res.ready;
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= scan_res;
        end
    end

    assign i_pix.ready       = pix_ready;
    assign o_res.valid       = r_out_vld;
    assign o_res.tall_row    = r_out.tall_row;
    assign o_res.tall_col    = r_out.tall_col;
    assign o_res.tall_height = r_out.tall_height;
    assign o_res.wide_row    = r_out.wide_row;
    assign o_res.wide_col    = r_out.wide_col;
    assign o_res.wide_width  = r_out.wide_width;
    assign o_res.big_row     = r_out.big_row;
    assign o_res.big_col     = r_out.big_col;
    assign o_res.big_area    = r_out.big_area;

endmodule

[sv/bgre_ram.sv]
module bgre_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 7,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port, old data on a collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[sv/bgre_scan.sv]
module bgre_scan (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [bgre_pkg::DIM_W-1:0]    i_rows,
    input  logic [bgre_pkg::DIM_W-1:0]    i_cols,
    input  logic [bgre_pkg::CNT_W-1:0]    i_total,
    output logic [bgre_pkg::ADDR_W-1:0]   o_rd_addr,
    input  logic                          i_rd_data,
    output logic                          o_done,
    output bgre_pkg::t_result             o_result
);

    // issue stage: walks the grid in reverse raster order
    logic                          r_busy;
    logic [bgre_pkg::ADDR_W-1:0]   r_addr;
    logic [bgre_pkg::IDX_W-1:0]    r_row;
    logic [bgre_pkg::IDX_W-1:0]    r_col;
    logic [bgre_pkg::IDX_W-1:0]    r_rows_m1;
    logic [bgre_pkg::IDX_W-1:0]    r_cols_m1;

    // stage 1: memory data back, runs computed
    logic                          r_s1_vld;
    logic [bgre_pkg::IDX_W-1:0]    r_s1_row;
    logic [bgre_pkg::IDX_W-1:0]    r_s1_col;
    logic                          r_s1_last_row;
    logic                          r_s1_last_col;
    logic                          r_s1_fwd;
    logic                          r_s1_end;
    logic [bgre_pkg::DIM_W-1:0]    r_h_last;
    logic [bgre_pkg::DIM_W-1:0]    r_w_last;

    // stage 2: run compare and area product
    logic                          r_s2_vld;
    logic [bgre_pkg::IDX_W-1:0]    r_s2_row;
    logic [bgre_pkg::IDX_W-1:0]    r_s2_col;
    logic [bgre_pkg::DIM_W-1:0]    r_s2_h;
    logic [bgre_pkg::DIM_W-1:0]    r_s2_w;
    logic                          r_s2_end;

    // stage 3: area compare
    logic                          r_s3_vld;
    logic [bgre_pkg::IDX_W-1:0]    r_s3_row;
    logic [bgre_pkg::IDX_W-1:0]    r_s3_col;
    logic [bgre_pkg::AREA_W-1:0]   r_s3_area;
    logic                          r_s3_end;

    logic                          r_done;
    bgre_pkg::t_result             r_best;

    logic [bgre_pkg::CNT_W-1:0]    total_m1;
    logic [bgre_pkg::DIM_W-1:0]    rows_m1;
    logic [bgre_pkg::DIM_W-1:0]    cols_m1;
    logic [bgre_pkg::DIM_W-1:0]    down_q;
    logic [bgre_pkg::DIM_W-1:0]    below;
    logic [bgre_pkg::DIM_W-1:0]    s1_h;
    logic [bgre_pkg::DIM_W-1:0]    s1_w;
    logic [2*bgre_pkg::DIM_W-1:0]  s2_prod;

    assign total_m1  = i_total - bgre_pkg::CNT_W'(1);
    assign rows_m1   = i_rows - bgre_pkg::DIM_W'(1);
    assign cols_m1   = i_cols - bgre_pkg::DIM_W'(1);
    assign o_rd_addr = r_addr;

    // down run of the row below, one entry per column
    bgre_ram #(
        .DEPTH (bgre_pkg::MAX_DIM),
        .WIDTH (bgre_pkg::DIM_W)
    ) u_down_mem (
        .i_clk   (i_clk),
        .i_we    (r_s1_vld),
        .i_waddr (r_s1_col),
        .i_wdata (s1_h),
        .i_raddr (r_col),
        .o_rdata (down_q)
    );

    // address walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_addr == '0) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_addr    <= total_m1[bgre_pkg::ADDR_W-1:0];
            r_row     <= rows_m1[bgre_pkg::IDX_W-1:0];
            r_col     <= cols_m1[bgre_pkg::IDX_W-1:0];
            r_rows_m1 <= rows_m1[bgre_pkg::IDX_W-1:0];
            r_cols_m1 <= cols_m1[bgre_pkg::IDX_W-1:0];
        end else if (r_busy) begin
            r_addr <= r_addr - bgre_pkg::ADDR_W'(1);
            if (r_col == '0) begin
                r_col <= r_cols_m1;
                r_row <= r_row - bgre_pkg::IDX_W'(1);
            end else begin
                r_col <= r_col - bgre_pkg::IDX_W'(1);
            end
        end
    end

    // stage 1 capture; forward when the cell below was computed last cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_row      <= r_row;
        r_s1_col      <= r_col;
        r_s1_last_row <= (r_row == r_rows_m1);
        r_s1_last_col <= (r_col == r_cols_m1);
        r_s1_fwd      <= r_s1_vld && (r_s1_col == r_col);
        r_s1_end      <= (r_addr == '0);
    end

    // run lengths of this cell
    always_comb begin
        if (r_s1_last_row) begin
            below = '0;
        end else if (r_s1_fwd) begin
            below = r_h_last;
        end else begin
            below = down_q;
        end
        s1_h = '0;
        s1_w = '0;
        if (i_rd_data) begin
            s1_h = below + bgre_pkg::DIM_W'(1);
            s1_w = r_s1_last_col ? bgre_pkg::DIM_W'(1) : r_w_last + bgre_pkg::DIM_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_h_last <= s1_h;
            r_w_last <= s1_w;
        end
    end

    // stage 2 capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_row <= r_s1_row;
        r_s2_col <= r_s1_col;
        r_s2_h   <= s1_h;
        r_s2_w   <= s1_w;
        r_s2_end <= r_s1_end;
    end

    assign s2_prod = r_s2_h * r_s2_w;

    // stage 3 capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_vld;
            r_done   <= r_s3_vld && r_s3_end;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_row  <= r_s2_row;
        r_s3_col  <= r_s2_col;
        r_s3_area <= s2_prod[bgre_pkg::AREA_W-1:0];
        r_s3_end  <= r_s2_end;
    end

    // running best; reverse order, so ties go to the later-seen cell
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_best <= '0;
        end else begin
            if (r_s2_vld && r_s2_h != '0 && r_s2_h >= r_best.tall_height) begin
                r_best.tall_height <= r_s2_h;
                r_best.tall_row    <= r_s2_row;
                r_best.tall_col    <= r_s2_col;
            end
            if (r_s2_vld && r_s2_w != '0 && r_s2_w >= r_best.wide_width) begin
                r_best.wide_width <= r_s2_w;
                r_best.wide_row   <= r_s2_row;
                r_best.wide_col   <= r_s2_col;
            end
            if (r_s3_vld && r_s3_area != '0 && r_s3_area >= r_best.big_area) begin
                r_best.big_area <= r_s3_area;
                r_best.big_row  <= r_s3_row;
                r_best.big_col  <= r_s3_col;
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_best;

endmodule

[tb/binary_grid_rectangle_extents_tb.sv]
module binary_grid_rectangle_extents_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 100;
    localparam int HOLD_CYCLES   = 600;
    localparam int RANDOM_PIXELS = 600;

    // expected extents of each loaded grid, kept in arrival order
    class extents_tracker;
        logic [bgre_pkg::DIM_W-1:0] rows_reg;
        logic [bgre_pkg::DIM_W-1:0] cols_reg;
        int unsigned                fill;
        bit                         cells [bgre_pkg::CELL_COUNT];
        bgre_pkg::t_result          pending_extents [$];
        int                         mismatches;

        function new();
            rows_reg   = bgre_pkg::DIM_W'(bgre_pkg::MAX_DIM);
            cols_reg   = bgre_pkg::DIM_W'(bgre_pkg::MAX_DIM);
            fill       = 0;
            mismatches = 0;
        endfunction

        // zero counts as one, above the maximum as the maximum
        static function int unsigned dim_of(logic [bgre_pkg::DIM_W-1:0] v);
            if (v == '0) return 1;
            if (v > bgre_pkg::MAX_DIM) return bgre_pkg::MAX_DIM;
            return v;
        endfunction

        function void set_reg(logic [bgre_pkg::CFG_IDX_W-1:0] idx,
                              logic [bgre_pkg::DIM_W-1:0] value);
            case (idx)
                bgre_pkg::CFG_ROWS: rows_reg = value;
                bgre_pkg::CFG_COLS: cols_reg = value;
                default: ;
            endcase
        endfunction

        // scan the stored grid for the tallest, widest and largest-area runs
        function bgre_pkg::t_result predict_extents();
            int unsigned nr, nc, r, c, j, h, w, a;
            int unsigned bh, hr, hc, bw, wr, wc, ba, ar, ac;
            bgre_pkg::t_result res;
            nr = dim_of(rows_reg);
            nc = dim_of(cols_reg);
            bh = 0; hr = 0; hc = 0;
            bw = 0; wr = 0; wc = 0;
            ba = 0; ar = 0; ac = 0;
            for (r = 0; r < nr; r++) begin
                for (c = 0; c < nc; c++) begin
                    if (!cells[r * nc + c]) continue;
                    h = 0;
                    for (j = r; j < nr && cells[j * nc + c]; j++) h++;
                    w = 0;
                    for (j = c; j < nc && cells[r * nc + j]; j++) w++;
                    // strict compares keep the first cell in raster order on ties
                    if (h > bh) begin
                        bh = h; hr = r; hc = c;
                    end
                    if (w > bw) begin
                        bw = w; wr = r; wc = c;
                    end
                    a = h * w;
                    if (a > ba) begin
                        ba = a; ar = r; ac = c;
                    end
                end
            end
            res.tall_row    = bgre_pkg::IDX_W'(hr);
            res.tall_col    = bgre_pkg::IDX_W'(hc);
            res.tall_height = bgre_pkg::DIM_W'(bh);
            res.wide_row    = bgre_pkg::IDX_W'(wr);
            res.wide_col    = bgre_pkg::IDX_W'(wc);
            res.wide_width  = bgre_pkg::DIM_W'(bw);
            res.big_row     = bgre_pkg::IDX_W'(ar);
            res.big_col     = bgre_pkg::IDX_W'(ac);
            res.big_area    = bgre_pkg::AREA_W'(ba);
            return res;
        endfunction

        // accepted pixel: store it and close the grid once the count is reached
        function void note_pixel(bit value);
            int unsigned total;
            total = dim_of(rows_reg) * dim_of(cols_reg);
            if (fill < bgre_pkg::CELL_COUNT) cells[fill] = value;
            fill++;
            if (fill >= total) begin
                pending_extents.push_back(predict_extents());
                fill = 0;
            end
        endfunction

        static function string show(bgre_pkg::t_result r);
            return $sformatf("tall=(%0d,%0d,%0d) wide=(%0d,%0d,%0d) big=(%0d,%0d,%0d)",
                             r.tall_row, r.tall_col, r.tall_height,
                             r.wide_row, r.wide_col, r.wide_width,
                             r.big_row, r.big_col, r.big_area);
        endfunction

        // accepted result against the oldest expectation
        function void check_result(bgre_pkg::t_result got);
            bgre_pkg::t_result want;
            bit                bad;
            if (pending_extents.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with none expected: got %s", show(got));
                return;
            end
            want = pending_extents.pop_front();
            bad = (got.tall_row !== want.tall_row) || (got.tall_col !== want.tall_col) ||
                  (got.tall_height !== want.tall_height) ||
                  (got.wide_row !== want.wide_row) || (got.wide_col !== want.wide_col) ||
                  (got.wide_width !== want.wide_width) ||
                  (got.big_row !== want.big_row) || (got.big_col !== want.big_col) ||
                  (got.big_area !== want.big_area);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("extents mismatch: expected %s, got %s", show(want), show(got));
            end
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [bgre_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [bgre_pkg::DIM_W-1:0]     i_cfg_data;

    bgre_pix_if pix_bus ();
    bgre_res_if res_bus ();

    extents_tracker sb = new();

    int pixels_sent  = 0;
    int results_seen = 0;
    bit sender_fast  = 1'b0;
    bit hold_go      = 1'b0;
    bit res_hold     = 1'b0;

    binary_grid_rectangle_extents u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_bus),
        .o_res      (res_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // idle cycles before a transaction, often none
    function automatic int draw_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 13);
    endfunction

    function automatic logic [bgre_pkg::DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 19))
            0: return '0;
            1: return bgre_pkg::DIM_W'($urandom_range(bgre_pkg::MAX_DIM + 1, 127));
            2: return bgre_pkg::DIM_W'(bgre_pkg::MAX_DIM);
            3, 4: return bgre_pkg::DIM_W'($urandom_range(9, bgre_pkg::MAX_DIM - 1));
            default: return bgre_pkg::DIM_W'($urandom_range(1, 8));
        endcase
    endfunction

    // keep random grids small, one long side at most
    function automatic void pick_geometry(output logic [bgre_pkg::DIM_W-1:0] r,
                                          output logic [bgre_pkg::DIM_W-1:0] c);
        r = pick_dim();
        c = pick_dim();
        if (extents_tracker::dim_of(r) * extents_tracker::dim_of(c) > 256)
            c = bgre_pkg::DIM_W'($urandom_range(1, 3));
    endfunction

    function automatic int pick_density();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 100;
            2: return $urandom_range(85, 99);
            default: return $urandom_range(20, 80);
        endcase
    endfunction

    // one pixel transaction
    task automatic send_pixel(input bit value);
        int gap;
        gap = sender_fast ? 0 : draw_gap();
        if (gap > 0) begin
            pix_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_bus.valid <= 1'b1;
        pix_bus.pixel <= value;
        @(posedge i_clk);
        while (!pix_bus.ready) @(posedge i_clk);
        sb.note_pixel(value);
        pixels_sent++;
    endtask

    task automatic send_fill(input int count, input int density);
        repeat (count) send_pixel($urandom_range(0, 99) < density);
    endtask

    // pixels until the current grid closes
    task automatic send_grid(input int density);
        do begin
            send_pixel($urandom_range(0, 99) < density);
        end while (sb.fill != 0);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        pix_bus.valid <= 1'b0;
        while (sb.pending_extents.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_grid(input int rows, input int cols);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= bgre_pkg::CFG_ROWS;
        i_cfg_data <= bgre_pkg::DIM_W'(rows);
        @(posedge i_clk);
        sb.set_reg(bgre_pkg::CFG_ROWS, bgre_pkg::DIM_W'(rows));
        i_cfg_idx  <= bgre_pkg::CFG_COLS;
        i_cfg_data <= bgre_pkg::DIM_W'(cols);
        @(posedge i_clk);
        sb.set_reg(bgre_pkg::CFG_COLS, bgre_pkg::DIM_W'(cols));
        i_cfg_we <= 1'b0;
    endtask

    // result receiver with random stalls and the long hold
    initial begin : result_sink
        int                gap;
        bgre_pkg::t_result got;
        res_bus.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            gap = draw_gap();
            if (gap > 0 || res_hold) begin
                res_bus.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
                while (res_hold) @(posedge i_clk);
            end
            res_bus.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_bus.valid) @(posedge i_clk);
            got.tall_row    = res_bus.tall_row;
            got.tall_col    = res_bus.tall_col;
            got.tall_height = res_bus.tall_height;
            got.wide_row    = res_bus.wide_row;
            got.wide_col    = res_bus.wide_col;
            got.wide_width  = res_bus.wide_width;
            got.big_row     = res_bus.big_row;
            got.big_col     = res_bus.big_col;
            got.big_area    = res_bus.big_area;
            sb.check_result(got);
            results_seen++;
        end
    end

    // long receiver hold so the result register and then the input back up
    initial begin : long_hold
        wait (hold_go);
        @(posedge i_clk);
        res_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        res_hold <= 1'b0;
    end

    // run limit
    initial begin : watchdog
        #5_000_000;
        $display("binary_grid_rectangle_extents_tb: FAIL");
        $finish;
    end

    // stimulus
    initial begin : stimulus
        logic [bgre_pkg::DIM_W-1:0] r, c;
        int                         density, total, base;
        bit                         first;

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= bgre_pkg::CFG_ROWS;
        i_cfg_data    <= '0;
        pix_bus.valid <= 1'b0;
        pix_bus.pixel <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset geometry, then a shape change part-way through the load
        send_fill(10, 50);
        drain();
        set_grid(2, 8);
        send_grid(50);

        // geometry shrunk below the pixels already loaded
        drain();
        set_grid(4, 4);
        send_fill(10, 50);
        drain();
        set_grid(2, 2);
        send_grid(50);

        // empty grid
        drain();
        set_grid(3, 5);
        send_grid(0);

        // zero rows taken as one: single cell, clear then set
        drain();
        set_grid(0, 1);
        send_grid(0);
        send_grid(100);

        // tallest run at full height, oversized row count
        drain();
        set_grid(127, 1);
        send_grid(100);

        // widest run at full width, column count just past the maximum
        drain();
        set_grid(1, bgre_pkg::MAX_DIM + 1);
        send_grid(100);

        // only the far corner set
        drain();
        set_grid(bgre_pkg::MAX_DIM, 2);
        send_fill(2 * bgre_pkg::MAX_DIM - 1, 0);
        send_pixel(1'b1);
        drain();
        set_grid(2, bgre_pkg::MAX_DIM);
        send_fill(2 * bgre_pkg::MAX_DIM - 1, 0);
        send_pixel(1'b1);

        // checkerboard: every run has length one, first set cell wins
        drain();
        set_grid(4, 5);
        for (int i = 0; i < 20; i++) send_pixel(((i / 5) + (i % 5)) % 2 == 1);

        // two equal vertical bars, ties go to the left one
        drain();
        set_grid(3, 4);
        for (int i = 0; i < 12; i++) send_pixel((i % 4 == 1) || (i % 4 == 3));

        // back-to-back grids against a stalled receiver
        drain();
        set_grid(3, 4);
        hold_go = 1'b1;
        sender_fast = 1'b1;
        repeat (6) send_grid(50);
        sender_fast = 1'b0;

        // random grids, with partial loads broken by a shape change
        base  = pixels_sent;
        first = 1'b1;
        while (pixels_sent - base < RANDOM_PIXELS) begin
            if (first || $urandom_range(0, 2) == 0) begin
                drain();
                pick_geometry(r, c);
                set_grid(int'(r), int'(c));
                first = 1'b0;
            end
            density     = pick_density();
            sender_fast = ($urandom_range(0, 4) == 0);
            total       = extents_tracker::dim_of(r) * extents_tracker::dim_of(c);
            if (total > 1 && $urandom_range(0, 7) == 0) begin
                send_fill($urandom_range(1, total - 1), density);
                drain();
                pick_geometry(r, c);
                set_grid(int'(r), int'(c));
            end
            send_grid(density);
        end
        sender_fast = 1'b0;

        // wind down
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_extents.size() == 0) begin
            $display("binary_grid_rectangle_extents_tb: PASS");
        end else begin
            $display("binary_grid_rectangle_extents_tb: FAIL");
        end
        $finish;
    end

endmodule

[binary_grid_rectangle_extents.f]
sv/bgre_pkg.sv
sv/bgre_pix_if.sv
sv/bgre_res_if.sv
sv/bgre_ram.sv
sv/bgre_scan.sv
sv/binary_grid_rectangle_extents.sv
tb/binary_grid_rectangle_extents_tb.sv
